[rtl/pancake_sort_engine_macros.svh]
// Assertion helpers used by pancake_sort_engine.sv.
`ifndef PANCAKE_SORT_ENGINE_MACROS_SVH
`define PANCAKE_SORT_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define PSE_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define PSE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pse_pkg.sv]
package pse_pkg;

  // Default sizing of the stack memory
  localparam int STACK_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 16;

  // Fixed payload widths of the channels
  localparam int KEY_W  = 16;
  localparam int FLIP_W = 7;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHK,
    ST_FIND,
    ST_RLO,
    ST_RHI,
    ST_WLO,
    ST_WHI,
    ST_EMIT_RD,
    ST_EMIT_LD
  } pse_state_t;

  // Control from the sequencer to the scan unit
  typedef struct packed {
    logic start;
    logic find;
  } scan_ctrl_t;

  // Status from the scan unit back to the sequencer
  typedef struct packed {
    logic done;
    logic asc;
  } scan_stat_t;

endpackage

[rtl/pse_if.sv]
// Key loading channel
interface pse_in_if import pse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_value;
  logic             last_in;

  modport source (output valid, output key_value, output last_in, input ready);
  modport sink   (input valid, input key_value, input last_in, output ready);
endinterface

// Sorted key channel
interface pse_out_if import pse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  sorted_key;
  logic [FLIP_W-1:0] flip_count;
  logic              overflow;
  logic              last_out;

  modport source (output valid, output sorted_key, output flip_count, output overflow,
                  output last_out, input ready);
  modport sink   (input valid, input sorted_key, input flip_count, input overflow,
                  input last_out, output ready);
endinterface

[rtl/pancake_sort_engine.sv]
// Pancake sort engine.
// load channel: one key per transaction, top of stack first; last_in closes the set.
// Up to STACK_DEPTH keys are kept in a one-port-read stack memory; further keys
// are dropped and the set is flagged with overflow on every result.
// After the last transaction the block sorts in place and accepts nothing more
// until the final result has been loaded into its output register.
// result channel: one transaction per stored key, ascending, each with the
// flip count of the set; last_out marks the final key.
// Loading accepts one key per cycle. Each sort pass runs an ascending check and a
// maximum search through the memory read port, and each prefix reversal swaps
// one pair at a time in states ST_RLO, ST_RHI, ST_WLO and ST_WHI, since both ends
// of a pair go through the single read port and single write port. Emission reads
// each key in ST_EMIT_RD and loads it into the output register in ST_EMIT_LD.
// A stalled receiver holds the output register; the next memory read waits.
// The final result may wait in the output register while the next set loads.
// Reset (rst, synchronous) empties the stack count, clears the overflow flag and
// the output valid; memory contents are not cleared and need no clearing pass.
`include "pancake_sort_engine_macros.svh"

module pancake_sort_engine import pse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pse_in_if.sink     load,
  pse_out_if.source  result
);

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  pse_state_t          state;
  pse_state_t          state_next;

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_after;
  logic [IW-1:0]       nm1;
  logic                ovf;
  logic [IW-1:0]       target;
  logic [IW-1:0]       lo;
  logic [IW-1:0]       hi;
  logic                lo_more;
  logic [KEY_BITS-1:0] tmp;
  logic [FLIP_W-1:0]   flips;
  logic                mid;
  logic                sink;
  logic [IW-1:0]       ek;

  logic                out_valid;
  logic [KEY_W-1:0]    out_key;
  logic [FLIP_W-1:0]   out_flips;
  logic                out_ovf;
  logic                out_last;

  logic                load_fire;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] ram_rdata;

  scan_ctrl_t          sctrl;
  scan_stat_t          sstat;
  logic [IW-1:0]       scan_lim;
  logic [IW-1:0]       scan_raddr;
  logic [IW-1:0]       top_idx;

  // Stack memory
  pse_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Ascending check and maximum search
  pse_scan #(
    .STACK_DEPTH (STACK_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (sctrl),
    .lim     (scan_lim),
    .rdata   (ram_rdata),
    .raddr   (scan_raddr),
    .stat    (sstat),
    .top_idx (top_idx)
  );

  // Common terms
  assign load_fire   = load.valid && load.ready;
  assign count_after = (count < CW'(STACK_DEPTH)) ? count + CW'(1) : count;
  assign nm1         = IW'(count - CW'(1));
  assign lo_more     = ({1'b0, lo} + (IW + 1)'(2)) < {1'b0, hi};
  assign scan_lim    = (state == ST_FIND) ? target : nm1;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (load_fire && load.last_in) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sstat.done) begin
          if (sstat.asc) begin
            state_next = ST_EMIT_RD;
          end else if (!mid) begin
            state_next = ST_FIND;
          end else begin
            state_next = ST_RLO;
          end
        end
      end
      ST_FIND: begin
        if (sstat.done) begin
          if (top_idx == target) begin
            state_next = (target == '0) ? ST_EMIT_RD : ST_CHK;
          end else if (top_idx != '0) begin
            state_next = ST_RLO;
          end else begin
            state_next = ST_CHK;
          end
        end
      end
      ST_RLO: state_next = ST_RHI;
      ST_RHI: state_next = ST_WLO;
      ST_WLO: state_next = ST_WHI;
      ST_WHI: begin
        if (lo_more) begin
          state_next = ST_RLO;
        end else if (sink && (target == '0)) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_CHK;
        end
      end
      ST_EMIT_RD: begin
        if (!out_valid || result.ready) begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_next = (ek == nm1) ? ST_LOAD : ST_EMIT_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Memory ports, handshake and scan control
  always_comb begin
    load.ready  = (state == ST_LOAD);
    sctrl.start = ((state_next == ST_CHK) || (state_next == ST_FIND)) &&
                  (state_next != state);
    sctrl.find  = (state == ST_FIND);
    ram_we      = 1'b0;
    ram_waddr   = lo;
    ram_wdata   = ram_rdata;
    ram_raddr   = lo;
    unique case (state) inside
      ST_LOAD: begin
        ram_we    = load_fire && (count < CW'(STACK_DEPTH));
        ram_waddr = count[IW-1:0];
        ram_wdata = KEY_BITS'(load.key_value);
      end
      ST_CHK, ST_FIND: ram_raddr = scan_raddr;
      ST_RHI:          ram_raddr = hi;
      ST_WLO: begin
        ram_we    = 1'b1;
        ram_waddr = lo;
        ram_wdata = ram_rdata;
      end
      ST_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi;
        ram_wdata = tmp;
      end
      ST_EMIT_RD:      ram_raddr = ek;
      default:         ram_raddr = lo;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sort datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      mid       <= 1'b0;
      sink      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (load_fire) begin
            count <= count_after;
            if (count == CW'(STACK_DEPTH)) begin
              ovf <= 1'b1;
            end
            if (load.last_in) begin
              target <= IW'(count_after - CW'(1));
              flips  <= '0;
              mid    <= 1'b0;
            end
          end
        end
        ST_CHK: begin
          if (sstat.done) begin
            ek <= '0;
            // Sink the maximum down to the target
            if (!sstat.asc && mid) begin
              lo    <= '0;
              hi    <= target;
              sink  <= 1'b1;
              flips <= flips + FLIP_W'(1);
            end
          end
        end
        ST_FIND: begin
          if (sstat.done) begin
            ek <= '0;
            if (top_idx == target) begin
              if (target != '0) begin
                target <= target - IW'(1);
                mid    <= 1'b0;
              end
            end else if (top_idx != '0) begin
              // Bring the maximum to the top
              lo    <= '0;
              hi    <= top_idx;
              sink  <= 1'b0;
              flips <= flips + FLIP_W'(1);
            end else begin
              mid <= 1'b1;
            end
          end
        end
        ST_RHI: tmp <= ram_rdata;
        ST_WHI: begin
          ek <= '0;
          if (lo_more) begin
            lo <= lo + IW'(1);
            hi <= hi - IW'(1);
          end else if (sink) begin
            sink <= 1'b0;
            mid  <= 1'b0;
            if (target != '0) begin
              target <= target - IW'(1);
            end
          end else begin
            mid <= 1'b1;
          end
        end
        ST_EMIT_LD: begin
          out_key   <= KEY_W'(ram_rdata);
          out_flips <= flips;
          out_ovf   <= ovf;
          out_last  <= (ek == nm1);
          if (ek == nm1) begin
            count <= '0;
            ovf   <= 1'b0;
          end else begin
            ek <= ek + IW'(1);
          end
        end
        default: begin
        end
      endcase

      // Hold a result until the receiver takes it
      if (state == ST_EMIT_LD) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.sorted_key = out_key;
  assign result.flip_count = out_flips;
  assign result.overflow   = out_ovf;
  assign result.last_out   = out_last;

  `PSE_CHECK(a_we_state, ram_we, (state == ST_LOAD || state == ST_WLO || state == ST_WHI), "memory written outside load or swap")
  `PSE_CHECK(a_count_cap, 1'b1, (count <= CW'(STACK_DEPTH)), "stack count beyond capacity")
  `PSE_CHECK(a_swap_order, (state == ST_RLO), (lo < hi), "swap pair out of order")
  `PSE_CHECK(a_emit_range, (state == ST_EMIT_LD), (CW'(ek) < count), "emission past stored keys")
  `PSE_CHECK(a_scan_done, sstat.done, (state == ST_CHK || state == ST_FIND), "scan finished outside a scan state")
  `PSE_CHECK_NEXT(a_emit_wait, (state == ST_EMIT_RD && out_valid && !result.ready), (state == ST_EMIT_RD), "emission advanced over a held result")

endmodule

[rtl/pse_ram.sv]
module pse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pse_scan.sv]
module pse_scan import pse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  scan_ctrl_t                     ctrl,
  input  logic [$clog2(STACK_DEPTH)-1:0] lim,
  input  logic [KEY_BITS-1:0]            rdata,
  output logic [$clog2(STACK_DEPTH)-1:0] raddr,
  output scan_stat_t                     stat,
  output logic [$clog2(STACK_DEPTH)-1:0] top_idx
);

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic              busy;
  logic              dv;
  logic [CW-1:0]     ridx;
  logic [IW-1:0]     didx;
  logic [KEY_BITS-1:0] refv;
  logic              asc;
  logic [IW-1:0]     top_r;
  logic              issue;
  logic              upd;
  logic              asc_now;

  // Walk addresses 0..lim, one read a cycle
  assign issue = busy && (ridx <= CW'(lim));
  assign raddr = ridx[IW-1:0];

  // Compare returning data against the previous key or the running maximum
  assign asc_now = asc && !((didx != '0) && (refv > rdata));
  assign upd     = (didx == '0) || (refv < rdata);
  assign top_idx = upd ? didx : top_r;

  assign stat.done = dv && (didx == lim);
  assign stat.asc  = asc_now;

  // Scan counters and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dv   <= 1'b0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      dv   <= 1'b0;
      ridx <= '0;
      asc  <= 1'b1;
    end else if (busy) begin
      dv   <= issue;
      didx <= ridx[IW-1:0];
      if (issue) begin
        ridx <= ridx + CW'(1);
      end
      if (dv) begin
        asc   <= asc_now;
        top_r <= top_idx;
        if (!ctrl.find || upd) begin
          refv <= rdata;
        end
      end
      if (stat.done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
